@@ hdl/bgv_pkg.sv @@
`default_nettype none
package bgv_pkg;

  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned CfgW      = 13;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned RgbW      = 24;
  localparam int unsigned NumW      = 20;
  localparam int unsigned DivW      = 14;
  localparam int unsigned QuoW      = 7;
  localparam int unsigned NumDiv    = 6;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 32;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMode   = 2'd2;

  localparam logic [1:0] ModeGrad  = 2'd0;
  localparam logic [1:0] ModeBoth  = 2'd1;

  localparam int unsigned DivRx = 0;
  localparam int unsigned DivRy = 1;
  localparam int unsigned DivG  = 2;
  localparam int unsigned DivB  = 3;
  localparam int unsigned DivV  = 4;
  localparam int unsigned DivVg = 5;

  typedef struct packed {
    logic [CoordW-1:0]                pos_x;
    logic [CoordW-1:0]                pos_y;
    logic [RgbW-1:0]                  pixel_rgb;
    logic                             in_frame;
    logic [NumDiv-1:0][NumW-1:0]      rem;
    logic [NumDiv-1:0][QuoW-1:0]      quo;
  } bgv_item_t;

  function automatic logic [7:0] sub_sat(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? 8'(a - b) : 8'd0;
  endfunction

endpackage
`default_nettype wire

@@ hdl/background_gradient_vignette_top.sv @@
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// in       | s_axis_tvalid/tready       | tdata: pos_x[11:0] pos_y[23:12] pixel_rgb[47:24]
// out      | m_axis_tvalid/tready       | tdata: out_rgb[23:0] in_frame[24], zeros above
// config   | cfg_we_i                   | cfg_idx_i, cfg_data_i (width, height, mode)
//
// One word per clock while the output is not stalled; the pipeline is an operand stage, seven
// restoring compare-subtract stages shared by six parallel dividers (one
// quotient bit each), and the output register.
// Reset clears valid bits and loads width 1024, height 768, mode 1.
// A stall at the output holds each occupied stage; bubbles still close up.
`default_nettype none
module background_gradient_vignette_top
  import bgv_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // pos_x, pos_y, pixel_rgb
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata    // out_rgb, in_frame, zero pad
);

  localparam int unsigned NumSt = QuoW + 2;

  logic [CfgW-1:0] width_q, height_q;
  logic [1:0]      mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(1024);
      height_q <= CfgW'(768);
      mode_q   <= ModeBoth;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        RegMode:   mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [CfgW-1:0] w, h, cw, ch;
  logic [DivW-1:0] vig_div;
  logic            vig_zero;
  logic [NumDiv-1:0][DivW-1:0] dsr;

  always_comb begin
    w = (width_q  > CfgW'(MAX_DIM)) ? CfgW'(MAX_DIM) : width_q;
    h = (height_q > CfgW'(MAX_DIM)) ? CfgW'(MAX_DIM) : height_q;
    cw = w >> 1;
    ch = h >> 1;
    vig_div = DivW'(cw) + DivW'(ch);
    vig_zero = (vig_div == '0);
    dsr[DivRx] = DivW'(w);
    dsr[DivRy] = DivW'(h);
    dsr[DivG]  = DivW'(h);
    dsr[DivB]  = DivW'(w) + DivW'(h);
    dsr[DivV]  = DivW'(w) + DivW'(h);
    dsr[DivVg] = vig_div;
  end

  logic [NumSt-1:0] vld_q;
  logic [NumSt-1:0] rdy;
  bgv_item_t        st_q [QuoW+1];
  logic [OutDataW-1:0] out_q;

  always_comb begin
    rdy[NumSt-1] = !vld_q[NumSt-1] || m_axis_tready;
    for (int k = NumSt - 2; k >= 0; k--) rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NumSt-1];
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NumSt; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // operand stage
  bgv_item_t s0_d;
  logic [CoordW-1:0] in_x, in_y;
  logic [CfgW-1:0]   dx, dy;
  logic [DivW-1:0]   man_dist;
  logic [CfgW-1:0]   sxy;

  always_comb begin
    in_x = s_axis_tdata[CoordW-1:0];
    in_y = s_axis_tdata[2*CoordW-1:CoordW];
    dx = (CfgW'(in_x) > cw) ? CfgW'(CfgW'(in_x) - cw) : CfgW'(cw - CfgW'(in_x));
    dy = (CfgW'(in_y) > ch) ? CfgW'(CfgW'(in_y) - ch) : CfgW'(ch - CfgW'(in_y));
    man_dist = DivW'(dx) + DivW'(dy);
    sxy  = CfgW'(in_x) + CfgW'(in_y);
    s0_d.pos_x     = in_x;
    s0_d.pos_y     = in_y;
    s0_d.pixel_rgb = s_axis_tdata[InDataW-1:2*CoordW];
    s0_d.in_frame  = (CfgW'(in_x) < w) && (CfgW'(in_y) < h);
    s0_d.rem[DivRx] = NumW'(in_x) * NumW'(28);
    s0_d.rem[DivRy] = NumW'(in_y) * NumW'(10);
    s0_d.rem[DivG]  = NumW'(in_y) * NumW'(92);
    s0_d.rem[DivB]  = NumW'(sxy)  * NumW'(120);
    s0_d.rem[DivV]  = NumW'(man_dist) * NumW'(56);
    s0_d.rem[DivVg] = NumW'(man_dist) * NumW'(48);
    s0_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) st_q[0] <= s0_d;
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= QuoW; k++) begin : g_div
    localparam int unsigned Bit = QuoW - k;
    bgv_item_t   div_d;
    logic [NumW:0] trial [NumDiv];
    always_comb begin
      div_d = st_q[k-1];
      for (int j = 0; j < NumDiv; j++) begin
        trial[j] = (NumW+1)'(dsr[j]) << Bit;
        if ({1'b0, div_d.rem[j]} >= trial[j]) begin
          div_d.rem[j]      = NumW'(div_d.rem[j] - trial[j][NumW-1:0]);
          div_d.quo[j][Bit] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[k]) st_q[k] <= div_d;
    end
  end

  // colour assembly
  bgv_item_t fin;
  logic [7:0] r, g, b, v, dark, gr, gg, gb, sr, sg, sb;
  logic [OutDataW-1:0] out_d;

  always_comb begin
    fin = st_q[QuoW];
    r = 8'd12 + 8'(fin.quo[DivRx]) + 8'(fin.quo[DivRy]);
    g = 8'd24 + 8'(fin.quo[DivG]);
    b = 8'd40 + 8'(fin.quo[DivB]);
    v = (8'(fin.quo[DivV]) > 8'd56) ? 8'd56 : 8'(fin.quo[DivV]);
    gr = sub_sat(r, v);
    gg = sub_sat(g, v);
    gb = sub_sat(b, v >> 1);
    dark = vig_zero ? 8'd0 : 8'(fin.quo[DivVg]);
    if (mode_q == ModeBoth) begin
      sr = gr; sg = gg; sb = gb;
    end else begin
      sr = fin.pixel_rgb[23:16];
      sg = fin.pixel_rgb[15:8];
      sb = fin.pixel_rgb[7:0];
    end
    out_d = '0;
    if (!fin.in_frame) begin
      out_d[RgbW-1:0] = fin.pixel_rgb;
    end else if (mode_q == ModeGrad) begin
      out_d[RgbW-1:0] = {gr, gg, gb};
      out_d[RgbW]     = 1'b1;
    end else begin
      out_d[RgbW-1:0] = {sub_sat(sr, dark), sub_sat(sg, dark), sub_sat(sb, dark)};
      out_d[RgbW]     = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NumSt-1]) out_q <= out_d;
  end

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bgv_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // pos_x, pos_y, pixel_rgb
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // out_rgb, in_frame, zero pad

  typedef struct packed {
    logic            in_frame;
    logic [RgbW-1:0] out_rgb;
  } pixel_out_t;

  pixel_out_t  expected_pixels[$];
  int          error_count = 0;
  logic [12:0] width_reg  = 13'd1024;
  logic [12:0] height_reg = 13'd768;
  logic [1:0]  mode_reg   = ModeBoth;
  bit          calm = 1'b0;

  background_gradient_vignette_top i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int unsigned sat_sub(int unsigned a, int unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic int unsigned absd(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic pixel_out_t shade_pixel(int unsigned x, int unsigned y,
                                             int unsigned pix);
    pixel_out_t  res;
    int unsigned w, h, sum, man_dist, v, r, g, b, maxd, dark;
    w = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
    h = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
    if (x >= w || y >= h) begin
      res.out_rgb = pix[23:0];
      res.in_frame = 1'b0;
      return res;
    end
    sum = w + h;
    man_dist = absd(x, w / 2) + absd(y, h / 2);
    if (mode_reg == ModeGrad || mode_reg == ModeBoth) begin
      v = (man_dist * 56) / sum;
      if (v > 56) v = 56;
      r = (12 + (x * 28) / w + (y * 10) / h) & 8'hFF;
      g = (24 + (y * 92) / h) & 8'hFF;
      b = (40 + ((x + y) * 120) / sum) & 8'hFF;
      r = sat_sub(r, v);
      g = sat_sub(g, v);
      b = sat_sub(b, v / 2);
    end else begin
      r = pix[23:16];
      g = pix[15:8];
      b = pix[7:0];
    end
    maxd = w / 2 + h / 2;
    if (mode_reg != ModeGrad && maxd != 0) begin
      dark = (man_dist * 48) / maxd;
      r = sat_sub(r, dark);
      g = sat_sub(g, dark);
      b = sat_sub(b, dark);
    end
    res.out_rgb = {r[7:0], g[7:0], b[7:0]};
    res.in_frame = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= calm || ($urandom_range(99) >= 28);
  end

  always @(posedge clk_i) begin
    pixel_out_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[24:0];
      if (expected_pixels.size() == 0) begin
        $error("unexpected word %h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.out_rgb !== want.out_rgb) begin
          $error("out_rgb: expected %h actual %h", want.out_rgb, got.out_rgb);
          error_count++;
        end
        if (got.in_frame !== want.in_frame) begin
          $error("in_frame: expected %b actual %b", want.in_frame, got.in_frame);
          error_count++;
        end
        if (m_axis_tdata[31:25] !== '0) begin
          $error("pad: expected 0 actual %h", m_axis_tdata[31:25]);
          error_count++;
        end
      end
    end
  end

  task automatic send_pixel(int unsigned x, int unsigned y, int unsigned pix);
    while (!calm && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pix[23:0], y[11:0], x[11:0]};
    expected_pixels.push_back(shade_pixel(x, y, pix));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[12:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegWidth) width_reg = value[12:0];
    else if (idx == RegHeight) height_reg = value[12:0];
    else if (idx == RegMode) mode_reg = value[1:0];
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned m);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegMode, m);
  endtask

  task automatic send_random(int unsigned count);
    int unsigned w, h;
    repeat (count) begin
      w = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
      h = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
      if ($urandom_range(9) < 8 && w > 0 && h > 0)
        send_pixel($urandom_range(w - 1 > 4095 ? 4095 : w - 1),
                   $urandom_range(h - 1 > 4095 ? 4095 : h - 1), $urandom);
      else
        send_pixel($urandom_range(4095), $urandom_range(4095), $urandom);
    end
  endtask

  task automatic test_reset_defaults();
    send_pixel(0, 0, 24'h123456);
    send_pixel(512, 384, 24'hFFFFFF);
    send_pixel(1023, 767, 0);
    send_pixel(1024, 10, 24'hABCDEF);
    send_pixel(10, 768, 24'h00FF00);
  endtask

  task automatic test_extremes();
    int unsigned m;
    for (m = 0; m < 4; m++) begin
      set_frame(4096, 4096, m);
      send_pixel(0, 0, 24'hFFFFFF);
      send_pixel(4095, 4095, 24'hFFFFFF);
      send_pixel(2048, 2048, 24'h808080);
      send_pixel(4095, 0, 0);
    end
    set_frame(1, 1, 1);
    send_pixel(0, 0, 24'hFFFFFF);
    send_pixel(1, 0, 24'h010203);
    set_frame(1, 1, 2);
    send_pixel(0, 0, 24'hFFFFFF);
    set_frame(0, 5, 0);
    send_pixel(0, 0, 24'h112233);
    set_frame(8191, 8191, 2);
    send_pixel(4095, 4095, 24'hFFFFFF);
    send_pixel(0, 4095, 24'hFFFFFF);
  endtask

  task automatic test_random_settings();
    int unsigned k;
    for (k = 0; k < 14; k++) begin
      calm = (k == 5);
      case ($urandom_range(3))
        0: set_frame($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(3));
        1: set_frame($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(3));
        2: set_frame($urandom_range(4096, 8191), $urandom_range(1, 300),
                     $urandom_range(3));
        default: set_frame($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(3));
      endcase
      send_random(62);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_random_settings();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ background_gradient_vignette_top.f @@
hdl/bgv_pkg.sv
hdl/background_gradient_vignette_top.sv
bench/testbench.sv
